### rtl/core/atdd_pkg.sv
// Shared types and constants for the alarm table core.
// No dependencies.
package atdd_pkg;
    localparam logic [1:0] CfgDedup    = 2'd0;
    localparam logic [1:0] CfgDebounce = 2'd1;
    localparam logic [1:0] CfgHold     = 2'd2;
    localparam logic [1:0] CfgMax      = 2'd3;
    localparam logic [7:0] AlphaFull   = 8'hFF;
    localparam logic [7:0] WarnLimit   = 8'd10;
    localparam logic [1:0] SevCrit     = 2'd0;
    localparam logic [1:0] SevWarn     = 2'd1;
    localparam logic [1:0] SevInfo     = 2'd2;

    typedef struct packed {
        logic [7:0]  id;
        logic [7:0]  pri;
        logic [23:0] color;
        logic [47:0] first;
        logic [47:0] lastt;
        logic [15:0] rep;
    } t_entry;

    // Classified work item passed from the front part to the back part.
    typedef struct packed {
        logic        tick;
        logic        bump_only;
        logic [7:0]  id;
        logic [7:0]  pri;
        logic [23:0] color;
        logic [47:0] now;
    } t_cmd;

    function automatic logic [1:0] severity_of(input logic [7:0] pri);
        if (pri == 8'd0) return SevCrit;
        if (pri < WarnLimit) return SevWarn;
        return SevInfo;
    endfunction
endpackage

### rtl/core/atdd_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module atdd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule

### rtl/core/atdd_front.sv
// Front part: accepts items, checks debounce and dedup stamps, emits commands.
// Depends on atdd_pkg and atdd_ram.
module atdd_front #(
    parameter int ID_COUNT = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_operation,
    input  logic [7:0]            i_alarm_id,
    input  logic [7:0]            i_priority_req,
    input  logic [23:0]           i_color,
    input  logic [47:0]           i_now_ms,
    input  logic [15:0]           i_dedup,
    input  logic [15:0]           i_debounce,
    input  logic                  i_q_full,
    output logic                  o_q_push,
    output atdd_pkg::t_cmd        o_q_cmd
);
    import atdd_pkg::*;
    localparam int AW = $clog2(ID_COUNT);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_PUSH = 3'b100
    } t_state;

    t_state          r_state, n_state;
    t_cmd            r_cmd;
    logic [AW-1:0]   r_sx;
    logic [ID_COUNT-1:0] r_bv, r_rv;
    logic [47:0]     w_bstamp, w_rstamp;
    logic            w_bhit, w_rhit, w_we, w_rwe, w_accept;

    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && (r_state == S_IDLE);

    logic [AW-1:0] w_addr;
    assign w_addr = w_accept ? AW'(i_alarm_id % ID_COUNT) : r_sx;

    assign w_bhit = r_bv[r_sx] && ({1'b0, r_cmd.now} < {1'b0, w_bstamp} + 49'(i_debounce));
    assign w_rhit = r_rv[r_sx] && ({1'b0, r_cmd.now} < {1'b0, w_rstamp} + 49'(i_dedup));
    assign w_we   = (r_state == S_READ) && !r_cmd.tick;
    assign w_rwe  = w_we && !w_bhit && !w_rhit;

    atdd_ram #(.WIDTH(48), .DEPTH(ID_COUNT)) u_bounce (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr),
        .i_wdata(r_cmd.now), .o_rdata(w_bstamp));
    atdd_ram #(.WIDTH(48), .DEPTH(ID_COUNT)) u_repeat (
        .i_clk(i_clk), .i_we(w_rwe), .i_addr(w_addr),
        .i_wdata(r_cmd.now), .o_rdata(w_rstamp));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid) n_state = S_READ;
            S_READ: n_state = S_PUSH;
            S_PUSH: if (!i_q_full) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_q_push = (r_state == S_PUSH) && !i_q_full;
    assign o_q_cmd  = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bv    <= '0;
            r_rv    <= '0;
        end else begin
            r_state <= n_state;
            if (w_we) r_bv[r_sx] <= 1'b1;
            if (w_rwe) r_rv[r_sx] <= 1'b1;
        end
        if (w_accept) begin
            r_sx            <= AW'(i_alarm_id % ID_COUNT);
            r_cmd.tick      <= i_operation;
            r_cmd.bump_only <= 1'b0;
            r_cmd.id        <= i_alarm_id;
            r_cmd.pri       <= i_priority_req;
            r_cmd.color     <= i_color;
            r_cmd.now       <= i_now_ms;
        end
        if (r_state == S_READ) r_cmd.bump_only <= !r_cmd.tick && (w_bhit || w_rhit);
    end
endmodule

### rtl/core/atdd_back.sv
// Back part: updates the table, sorts and trims it, and streams the list.
// Depends on atdd_pkg.
module atdd_back #(
    parameter int TABLE_SLOTS = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    output logic            o_q_pop,
    input  atdd_pkg::t_cmd  i_q_cmd,
    input  logic [15:0]     i_hold,
    input  logic [3:0]      i_max,
    output logic            o_valid,
    input  logic            i_stall,
    output logic            o_entry_valid,
    output logic [7:0]      o_entry_id,
    output logic [7:0]      o_entry_priority,
    output logic [1:0]      o_entry_severity,
    output logic [31:0]     o_entry_color,
    output logic [47:0]     o_first_seen,
    output logic [47:0]     o_last_seen,
    output logic [15:0]     o_repeat_count,
    output logic            o_has_critical,
    output logic            o_queried_active,
    output logic            o_last
);
    import atdd_pkg::*;
    localparam int NS = TABLE_SLOTS + 1;
    localparam int CW = $clog2(NS + 1);
    localparam int IW = (NS > 1) ? $clog2(NS) : 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_UPD  = 5'b00010,
        S_SORT = 5'b00100,
        S_TRIM = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state        r_state, n_state;
    t_cmd          r_cmd;
    t_entry        r_t [NS];
    logic [NS-1:0] r_v;
    logic [CW-1:0] r_n;
    logic [IW-1:0] r_k;
    logic          r_crit, r_q;
    logic          r_odd;
    logic [IW-1:0] r_pass;
    logic          r_ready;

    logic [NS-1:0] w_hit;
    logic [NS-1:0] w_keep;
    logic          w_found;
    logic [CW-1:0] w_lim;
    logic          w_last;

    always_comb begin
        w_found = 1'b0;
        for (int i = 0; i < NS; i++) begin
            w_hit[i]  = r_v[i] && (r_t[i].id == r_cmd.id) && !w_found;
            if (w_hit[i]) w_found = 1'b1;
            w_keep[i] = r_v[i] &&
                !({1'b0, r_cmd.now} > {1'b0, r_t[i].lastt} + 49'(i_hold));
        end
        w_lim = (int'(i_max) > TABLE_SLOTS) ? CW'(TABLE_SLOTS) : CW'(i_max);
    end

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;
    assign w_last  = (r_n == 0) || (CW'(r_k) == r_n - CW'(1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_q_valid) n_state = S_UPD;
            S_UPD:  n_state = (r_cmd.tick || !r_cmd.bump_only) ? S_SORT : S_TRIM;
            S_SORT: if (r_pass == IW'(NS - 1)) n_state = S_TRIM;
            S_TRIM: n_state = S_OUT;
            S_OUT:  if (o_valid && !i_stall && w_last) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Odd-even transposition sort over valid-first keys keeps equal priorities in order.
    function automatic logic swap_ok(input logic va, input logic vb,
                                     input logic [7:0] pa, input logic [7:0] pb);
        return (!va && vb) || (va && vb && pa > pb);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_v     <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_UPD: begin
                    if (r_cmd.tick) begin
                        r_v <= w_keep;
                    end else if (!w_found && !r_cmd.bump_only) begin
                        r_v[NS-1] <= 1'b1;
                    end
                end
                S_SORT: begin
                    for (int i = 0; i + 1 < NS; i++) begin
                        if ((i % 2) == int'(r_odd) &&
                            swap_ok(r_v[i], r_v[i+1], r_t[i].pri, r_t[i+1].pri)) begin
                            r_v[i]   <= r_v[i+1];
                            r_v[i+1] <= r_v[i];
                        end
                    end
                end
                S_TRIM: begin
                    for (int i = 0; i < NS; i++)
                        if ((CW'(i) >= w_lim && r_cmd.bump_only == 1'b0) || i == NS - 1)
                            r_v[i] <= 1'b0;
                end
                default: ;
            endcase
        end
        case (r_state)
            S_IDLE: if (i_q_valid) r_cmd <= i_q_cmd;
            S_UPD: begin
                r_odd  <= 1'b0;
                r_pass <= '0;
                if (!r_cmd.tick) begin
                    for (int i = 0; i < NS; i++) begin
                        if (w_hit[i]) begin
                            if (r_t[i].rep != 16'hFFFF) r_t[i].rep <= r_t[i].rep + 16'd1;
                            r_t[i].lastt <= r_cmd.now;
                            if (!r_cmd.bump_only) begin
                                r_t[i].pri   <= r_cmd.pri;
                                r_t[i].color <= r_cmd.color;
                            end
                        end
                    end
                    if (!w_found && !r_cmd.bump_only) begin
                        r_t[NS-1].id    <= r_cmd.id;
                        r_t[NS-1].pri   <= r_cmd.pri;
                        r_t[NS-1].color <= r_cmd.color;
                        r_t[NS-1].first <= r_cmd.now;
                        r_t[NS-1].lastt <= r_cmd.now;
                        r_t[NS-1].rep   <= 16'd0;
                    end
                end
            end
            S_SORT: begin
                r_odd  <= !r_odd;
                r_pass <= r_pass + IW'(1);
                for (int i = 0; i + 1 < NS; i++) begin
                    if ((i % 2) == int'(r_odd) &&
                        swap_ok(r_v[i], r_v[i+1], r_t[i].pri, r_t[i+1].pri)) begin
                        r_t[i]   <= r_t[i+1];
                        r_t[i+1] <= r_t[i];
                    end
                end
            end
            S_TRIM: begin
                r_k <= '0;
            end
            S_OUT: if (o_valid && !i_stall) r_k <= r_k + IW'(1);
            default: ;
        endcase
    end

    // Count, critical flag and query flag follow the trimmed valid bits.
    logic [CW-1:0] w_cnt;
    logic          w_crit, w_q;
    always_comb begin
        w_cnt  = '0;
        w_crit = 1'b0;
        w_q    = 1'b0;
        for (int i = 0; i < NS; i++) begin
            if (r_v[i]) begin
                w_cnt = w_cnt + CW'(1);
                if (r_t[i].pri == 8'd0) w_crit = 1'b1;
                if (r_t[i].id == r_cmd.id) w_q = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_TRIM) begin
            r_n    <= '0;
        end
        if (r_state == S_OUT && !r_ready) begin
            r_n    <= w_cnt;
            r_crit <= w_crit;
            r_q    <= w_q;
        end
    end

    // At the start of output, r_ready is held low while count and flags register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ready <= 1'b0;
        else r_ready <= (r_state == S_OUT) && !(n_state == S_IDLE);
    end

    t_entry w_e;
    assign w_e = r_t[r_k];
    assign o_valid          = (r_state == S_OUT) && r_ready;
    assign o_entry_valid    = (r_n != 0);
    assign o_entry_id       = (r_n != 0) ? w_e.id : 8'd0;
    assign o_entry_priority = (r_n != 0) ? w_e.pri : 8'd0;
    assign o_entry_severity = (r_n != 0) ? severity_of(w_e.pri) : 2'd0;
    assign o_entry_color    = (r_n != 0) ? {AlphaFull, w_e.color} : 32'd0;
    assign o_first_seen     = (r_n != 0) ? w_e.first : 48'd0;
    assign o_last_seen      = (r_n != 0) ? w_e.lastt : 48'd0;
    assign o_repeat_count   = (r_n != 0) ? w_e.rep : 16'd0;
    assign o_has_critical   = r_crit;
    assign o_queried_active = r_q;
    assign o_last           = w_last;
endmodule

### rtl/core/alarm_table_debounce_dedup_hold_core.sv
// Top level of the alarm table core: front, two-entry command queue, back.
// A push that only merges into an existing entry skips the sort; the odd-even sort passes
// and the result stream, which the output stall can hold, set the rate. The front can take
// new items while the back works, until the command queue is full.
// Reset clears table valid bits, stamp valid bits, queue and state registers, and loads config defaults.
module alarm_table_debounce_dedup_hold_core #(
    parameter int TABLE_SLOTS = 8,
    parameter int ID_COUNT    = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic [7:0]  i_alarm_id,
    input  logic [7:0]  i_priority_req,
    input  logic [7:0]  i_color_red,
    input  logic [7:0]  i_color_green,
    input  logic [7:0]  i_color_blue,
    input  logic [47:0] i_now_ms,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_entry_valid,
    output logic [7:0]  o_entry_id,
    output logic [7:0]  o_entry_priority,
    output logic [1:0]  o_entry_severity,
    output logic [31:0] o_entry_color,
    output logic [47:0] o_first_seen,
    output logic [47:0] o_last_seen,
    output logic [15:0] o_repeat_count,
    output logic        o_has_critical,
    output logic        o_queried_active,
    output logic        o_last
);
    import atdd_pkg::*;

    logic [15:0] r_dedup, r_debounce, r_hold;
    logic [3:0]  r_max;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dedup    <= 16'd5000;
            r_debounce <= 16'd100;
            r_hold     <= 16'd3000;
            r_max      <= 4'd3;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CfgDedup:    r_dedup    <= i_cfg_data;
                CfgDebounce: r_debounce <= i_cfg_data;
                CfgHold:     r_hold     <= i_cfg_data;
                CfgMax:      r_max      <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    logic f_push, q_pop;
    t_cmd f_cmd;
    t_cmd r_q [2];
    logic [1:0] r_cnt;
    logic r_rd, r_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (f_push) r_wr <= !r_wr;
            if (q_pop) r_rd <= !r_rd;
            r_cnt <= r_cnt + {1'b0, f_push} - {1'b0, q_pop};
        end
        if (f_push) r_q[r_wr] <= f_cmd;
    end

    atdd_front #(.ID_COUNT(ID_COUNT)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_operation(i_operation), .i_alarm_id(i_alarm_id),
        .i_priority_req(i_priority_req),
        .i_color({i_color_red, i_color_green, i_color_blue}),
        .i_now_ms(i_now_ms), .i_dedup(r_dedup), .i_debounce(r_debounce),
        .i_q_full(r_cnt == 2'd2), .o_q_push(f_push), .o_q_cmd(f_cmd));

    atdd_back #(.TABLE_SLOTS(TABLE_SLOTS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(r_cnt != 2'd0), .o_q_pop(q_pop),
        .i_q_cmd(r_q[r_rd]), .i_hold(r_hold), .i_max(r_max),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_entry_valid(o_entry_valid), .o_entry_id(o_entry_id),
        .o_entry_priority(o_entry_priority), .o_entry_severity(o_entry_severity),
        .o_entry_color(o_entry_color), .o_first_seen(o_first_seen),
        .o_last_seen(o_last_seen), .o_repeat_count(o_repeat_count),
        .o_has_critical(o_has_critical), .o_queried_active(o_queried_active),
        .o_last(o_last));
endmodule

### sim/alarm_table_debounce_dedup_hold_core_test.sv
// Self-checking testbench for the alarm table core: directed table, then random pushes and ticks.
// A behavioral copy of the alarm table predicts every result list; depends on atdd_pkg and the core.
module alarm_table_debounce_dedup_hold_core_test;
    import atdd_pkg::*;

    localparam int SLOTS = 8;
    localparam int WATCHDOG = 20000;
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct {
        logic        op;
        logic [7:0]  id;
        logic [7:0]  pri;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [47:0] now;
    } t_alarm_item;

    typedef struct packed {
        logic        ev;
        logic [7:0]  id;
        logic [7:0]  pri;
        logic [1:0]  sev;
        logic [31:0] color;
        logic [47:0] first;
        logic [47:0] lastt;
        logic [15:0] rep;
        logic        crit;
        logic        q;
        logic        last;
    } t_listing;

    typedef struct {
        t_alarm_item item;
        logic        checked;
        t_listing    want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_operation = 1'b0;
    logic [7:0]  i_alarm_id = '0;
    logic [7:0]  i_priority_req = '0;
    logic [7:0]  i_color_red = '0;
    logic [7:0]  i_color_green = '0;
    logic [7:0]  i_color_blue = '0;
    logic [47:0] i_now_ms = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        o_valid;
    logic        i_stall = 1'b1;
    logic        o_entry_valid;
    logic [7:0]  o_entry_id;
    logic [7:0]  o_entry_priority;
    logic [1:0]  o_entry_severity;
    logic [31:0] o_entry_color;
    logic [47:0] o_first_seen;
    logic [47:0] o_last_seen;
    logic [15:0] o_repeat_count;
    logic        o_has_critical;
    logic        o_queried_active;
    logic        o_last;

    alarm_table_debounce_dedup_hold_core i_dut (.*);

    always #5 i_clk = ~i_clk;

    // Predictor state.
    t_entry      active_tab[$];
    logic        bounce_ok[256];
    logic [47:0] bounce_at[256];
    logic        dedup_ok[256];
    logic [47:0] dedup_at[256];
    logic [15:0] cfg_dedup = 16'd5000;
    logic [15:0] cfg_debounce = 16'd100;
    logic [15:0] cfg_hold = 16'd3000;
    logic [3:0]  cfg_max = 4'd3;

    t_listing pending_list[$];
    int       errors = 0;
    int       items_sent = 0;
    int       lists_seen = 0;
    int       idle_cycles = 0;
    bit       hold_req = 1'b0;
    bit       hold_taken = 1'b0;
    int       hold_cnt = 0;
    bit       done = 1'b0;
    logic [47:0] clock_ms = 48'd0;

    function automatic logic [1:0] sev_for(logic [7:0] p);
        if (p == 8'd0) return SevCrit;
        if (p < 8'd10) return SevWarn;
        return SevInfo;
    endfunction

    function automatic void sort_and_trim();
        int lim;
        t_entry k;
        int j;
        for (int i = 1; i < active_tab.size(); i++) begin
            k = active_tab[i];
            j = i - 1;
            while (j >= 0 && active_tab[j].pri > k.pri) begin
                active_tab[j + 1] = active_tab[j];
                j--;
            end
            active_tab[j + 1] = k;
        end
        lim = (cfg_max > SLOTS) ? SLOTS : cfg_max;
        while (active_tab.size() > lim) void'(active_tab.pop_back());
    endfunction

    function automatic int find_alarm(logic [7:0] id);
        foreach (active_tab[i]) if (active_tab[i].id == id) return i;
        return -1;
    endfunction

    function automatic void touch(int f, logic [47:0] now);
        if (f < 0) return;
        if (active_tab[f].rep != 16'hFFFF) active_tab[f].rep++;
        active_tab[f].lastt = now;
    endfunction

    function automatic void predict_listing(t_alarm_item it);
        int f;
        logic crit;
        logic q;
        t_entry kept[$];
        t_entry e;
        t_listing l;
        if (it.op == OP_PUSH) begin
            f = find_alarm(it.id);
            if (bounce_ok[it.id] && {1'b0, it.now} < {1'b0, bounce_at[it.id]} + cfg_debounce) begin
                bounce_at[it.id] = it.now;
                touch(f, it.now);
            end else begin
                bounce_at[it.id] = it.now;
                bounce_ok[it.id] = 1'b1;
                if (dedup_ok[it.id] && {1'b0, it.now} < {1'b0, dedup_at[it.id]} + cfg_dedup) begin
                    touch(f, it.now);
                end else begin
                    if (f >= 0) begin
                        touch(f, it.now);
                        active_tab[f].pri = it.pri;
                        active_tab[f].color = {it.r, it.g, it.b};
                    end else begin
                        e = '{it.id, it.pri, {it.r, it.g, it.b}, it.now, it.now, 16'd0};
                        active_tab.insert(active_tab.size(), e);
                    end
                    dedup_at[it.id] = it.now;
                    dedup_ok[it.id] = 1'b1;
                    sort_and_trim();
                end
            end
        end else begin
            foreach (active_tab[i])
                if (!({1'b0, it.now} > {1'b0, active_tab[i].lastt} + cfg_hold))
                    kept.insert(kept.size(), active_tab[i]);
            active_tab = kept;
            sort_and_trim();
        end
        crit = 1'b0;
        foreach (active_tab[i]) if (active_tab[i].pri == 8'd0) crit = 1'b1;
        q = find_alarm(it.id) >= 0;
        if (active_tab.size() == 0) begin
            l = '{1'b0, 8'd0, 8'd0, 2'd0, 32'd0, 48'd0, 48'd0, 16'd0, 1'b0, 1'b0, 1'b1};
            pending_list.insert(pending_list.size(), l);
        end
        foreach (active_tab[i]) begin
            e = active_tab[i];
            l = '{1'b1, e.id, e.pri, sev_for(e.pri), {AlphaFull, e.color}, e.first, e.lastt,
                  e.rep, crit, q, i == active_tab.size() - 1};
            pending_list.insert(pending_list.size(), l);
        end
    endfunction

    task automatic send_alarm(t_alarm_item it);
        i_valid <= 1'b1;
        i_operation <= it.op;
        i_alarm_id <= it.id;
        i_priority_req <= it.pri;
        i_color_red <= it.r;
        i_color_green <= it.g;
        i_color_blue <= it.b;
        i_now_ms <= it.now;
        do @(posedge i_clk); while (o_stall);
        predict_listing(it);
        items_sent++;
        if ($urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3))
                @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_list.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CfgDedup: cfg_dedup = val;
            CfgDebounce: cfg_debounce = val;
            CfgHold: cfg_hold = val;
            default: cfg_max = val[3:0];
        endcase
        @(posedge i_clk);
    endtask

    // Output side: random stalls plus one long hold-off, then compare.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b1;
        end else begin
            if (o_valid && !i_stall) begin
                lists_seen++;
                if (pending_list.size() == 0) begin
                    $display("%0t: unexpected result id=%0d", $time, o_entry_id);
                    errors++;
                end else begin
                    t_listing w;
                    t_listing g;
                    w = pending_list.pop_front();
                    g = '{o_entry_valid, o_entry_id, o_entry_priority, o_entry_severity,
                          o_entry_color, o_first_seen, o_last_seen, o_repeat_count,
                          o_has_critical, o_queried_active, o_last};
                    if (g != w) begin
                        $display("%0t: mismatch expected %p actual %p", $time, w, g);
                        errors++;
                    end
                end
            end
            if (hold_cnt != 0) begin
                i_stall <= 1'b1;
                hold_cnt <= hold_cnt - 1;
            end else if (hold_req && !hold_taken) begin
                i_stall <= 1'b1;
                hold_cnt <= 400;
                hold_taken <= 1'b1;
            end else if ($urandom_range(0, 19) == 0) i_stall <= 1'b1;
            else if ($urandom_range(0, 2) == 0) i_stall <= 1'b0;
            else i_stall <= i_stall && ($urandom_range(0, 1) == 0);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG && !done) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic t_alarm_item rand_alarm();
        t_alarm_item it;
        it.op = ($urandom_range(0, 5) == 0) ? OP_TICK : OP_PUSH;
        it.id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 11));
        it.pri = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
        it.r = 8'($urandom);
        it.g = 8'($urandom);
        it.b = 8'($urandom);
        it.now = clock_ms;
        return it;
    endfunction

    t_row rows[$];

    function automatic void add_row(t_alarm_item it, logic chk, t_listing want);
        t_row row;
        row.item = it;
        row.checked = chk;
        row.want = want;
        rows.insert(rows.size(), row);
    endfunction

    initial begin
        t_alarm_item it;
        t_listing nil;
        int span;
        nil = '{1'b0, 8'd0, 8'd0, 2'd0, 32'd0, 48'd0, 48'd0, 16'd0, 1'b0, 1'b0, 1'b1};
        foreach (bounce_ok[i]) begin
            bounce_ok[i] = 1'b0;
            dedup_ok[i] = 1'b0;
        end
        add_row('{OP_TICK, 8'd5, 8'd0, 8'd0, 8'd0, 8'd0, 48'd0}, 1'b1, nil);
        add_row('{OP_PUSH, 8'd1, 8'd0, 8'hFF, 8'h00, 8'hFF, 48'd10}, 1'b1,
                '{1'b1, 8'd1, 8'd0, SevCrit, 32'hFFFF00FF, 48'd10, 48'd10, 16'd0,
                  1'b1, 1'b1, 1'b1});
        add_row('{OP_PUSH, 8'd1, 8'd4, 8'd1, 8'd2, 8'd3, 48'd50}, 1'b0, nil);
        add_row('{OP_PUSH, 8'd1, 8'd4, 8'd1, 8'd2, 8'd3, 48'd1000}, 1'b0, nil);
        add_row('{OP_PUSH, 8'd255, 8'd255, 8'h00, 8'hFF, 8'h00, 48'd1200}, 1'b0, nil);
        add_row('{OP_PUSH, 8'd7, 8'd9, 8'h12, 8'h34, 8'h56, 48'd1300}, 1'b0, nil);
        add_row('{OP_PUSH, 8'd8, 8'd9, 8'hAA, 8'h55, 8'hAA, 48'd1400}, 1'b0, nil);
        add_row('{OP_PUSH, 8'd9, 8'd10, 8'h01, 8'h02, 8'h04, 48'd1500}, 1'b0, nil);
        add_row('{OP_PUSH, 8'd200, 8'd4, 8'h0, 8'h0, 8'h0, 48'd1510}, 1'b0, nil);
        add_row('{OP_PUSH, 8'd1, 8'd200, 8'h10, 8'h20, 8'h30, 48'd7000}, 1'b0, nil);
        add_row('{OP_TICK, 8'd1, 8'd0, 8'h0, 8'h0, 8'h0, 48'd9000}, 1'b0, nil);
        add_row('{OP_TICK, 8'd7, 8'd0, 8'h0, 8'h0, 8'h0, 48'd20000}, 1'b0, nil);
        add_row('{OP_PUSH, 8'd3, 8'd0, 8'h0, 8'h0, 8'h0, 48'hFFFF_FFFF_FFF0}, 1'b0, nil);
        add_row('{OP_PUSH, 8'd3, 8'd0, 8'h0, 8'h0, 8'h0, 48'hFFFF_FFFF_FFFF}, 1'b0, nil);
        add_row('{OP_PUSH, 8'd4, 8'd1, 8'h0, 8'h0, 8'h0, 48'd5}, 1'b0, nil);
        add_row('{OP_TICK, 8'd4, 8'd0, 8'h0, 8'h0, 8'h0, 48'hFFFF_FFFF_FFFF}, 1'b0, nil);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) begin
            send_alarm(rows[r].item);
            if (rows[r].checked && pending_list.size() > 0) begin
                if (pending_list[pending_list.size() - 1] != rows[r].want) begin
                    $display("%0t: mismatch expected %p actual %p", $time, rows[r].want,
                             pending_list[pending_list.size() - 1]);
                    errors++;
                end
            end
        end
        drain();

        // Several register settings, extremes included; table fill and trim each phase.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_reg(CfgMax, 16'd8); write_reg(CfgDedup, 16'd0);
                    write_reg(CfgDebounce, 16'd0); write_reg(CfgHold, 16'd0);
                end
                1: begin
                    write_reg(CfgMax, 16'd15); write_reg(CfgDedup, 16'd200);
                    write_reg(CfgDebounce, 16'd20); write_reg(CfgHold, 16'd400);
                end
                2: begin
                    write_reg(CfgMax, 16'd1); write_reg(CfgDedup, 16'hFFFF);
                    write_reg(CfgDebounce, 16'hFFFF); write_reg(CfgHold, 16'hFFFF);
                end
                3: begin
                    write_reg(CfgMax, 16'd0); write_reg(CfgDedup, 16'd50);
                end
                4: begin
                    write_reg(CfgMax, 16'd5); write_reg(CfgDedup, 16'd300);
                    write_reg(CfgDebounce, 16'd30); write_reg(CfgHold, 16'd600);
                end
                default: begin
                    write_reg(CfgMax, 16'd8); write_reg(CfgDedup, 16'd5000);
                    write_reg(CfgDebounce, 16'd100); write_reg(CfgHold, 16'd3000);
                end
            endcase
            span = (phase == 2) ? 100000 : 150;
            for (int n = 0; n < (phase == 3 ? 20 : 60); n++) begin
                clock_ms = clock_ms + (($urandom_range(0, 4) == 0) ? $urandom_range(0, span * 10)
                                                                   : $urandom_range(0, span));
                if ($urandom_range(0, 49) == 0) clock_ms = 48'($urandom) << $urandom_range(0, 16);
                it = rand_alarm();
                if (phase == 4 && n == 10) hold_req = 1'b1;
                send_alarm(it);
            end
            drain();
        end

        done = 1'b1;
        $display("Covered %0d items and %0d results over six register settings,", items_sent,
                 lists_seen);
        $display("with debounce, dedup, hold expiry, trims and output back-pressure.");
        if (errors == 0 && pending_list.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
